>>> rtl/core/dks_pkg.sv
`default_nettype none
package dks_pkg;

    localparam int NUM_KEYS = 5;

    localparam int KEY_LEFT  = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_UP    = 2;
    localparam int KEY_DOWN  = 3;
    localparam int KEY_MID   = 4;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd40;

    localparam logic [6:0] MS_LAST     = 7'd99;
    localparam logic [3:0] TENTH_LAST  = 4'd9;
    localparam logic [5:0] SECOND_LAST = 6'd59;
    localparam logic [6:0] MINUTE_LAST = 7'd99;

    localparam logic [1:0] PRESET_RESET = 2'd1;
    localparam logic [1:0] PRESET_0     = 2'd0;
    localparam logic [1:0] PRESET_1     = 2'd1;
    localparam logic [1:0] PRESET_2     = 2'd2;
    localparam logic [1:0] PRESET_3     = 2'd3;

    localparam logic [4:0] REDRAW_MASK = 5'b01011;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
        logic       running;
        logic       theme_red;
        logic [1:0] offset_index;
        logic [5:0] offset_x;
        logic [6:0] offset_y;
        logic       redraw_ui;
        logic [4:0] press_mask;
    } t_result;

    function automatic logic [5:0] gap_x(input logic [1:0] idx);
        logic [5:0] v;
        v = 6'd0;
        case (idx)
            PRESET_1: v = 6'd35;
            default:  v = 6'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] gap_y(input logic [1:0] idx);
        logic [6:0] v;
        v = 7'd0;
        case (idx)
            PRESET_2: v = 7'd80;
            default:  v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] next_preset(input logic [1:0] idx);
        logic [1:0] v;
        v = PRESET_1;
        unique case (idx)
            PRESET_0: v = PRESET_1;
            PRESET_1: v = PRESET_2;
            PRESET_2: v = PRESET_0;
            PRESET_3: v = PRESET_1;
            default:  v = PRESET_1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/dks_lane.sv
`default_nettype none
module dks_lane
    import dks_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_level,
    input  wire logic [7:0] i_debounce,
    output logic            o_press
);

    localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_raw, n_raw;
    logic                   r_stable, n_stable;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [CMP_W-1:0]       count_ext, deb_ext;

    always_comb begin
        n_raw   = r_raw;
        n_count = r_count;
        if (i_level != r_raw) begin
            n_raw   = i_level;
            n_count = '0;
        end else if (r_count != COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end
        count_ext = CMP_W'(n_count);
        deb_ext   = CMP_W'(i_debounce);
        n_stable  = r_stable;
        o_press   = 1'b0;
        if (count_ext >= deb_ext && r_stable != i_level) begin
            n_stable = i_level;
            o_press  = ~i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b1;
            r_stable <= 1'b1;
            r_count  <= '0;
        end else if (i_step) begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/dks_merge.sv
`default_nettype none
module dks_merge
    import dks_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic [NUM_KEYS-1:0] i_press,
    output t_result                  o_result
);

    logic [6:0] r_ms, n_ms;
    logic [3:0] r_tenth, n_tenth;
    logic [5:0] r_second, n_second;
    logic [6:0] r_minute, n_minute;
    logic       r_run, n_run;
    logic       r_red, n_red;
    logic [1:0] r_preset, n_preset;

    always_comb begin
        n_ms     = r_ms;
        n_tenth  = r_tenth;
        n_second = r_second;
        n_minute = r_minute;
        n_run    = r_run;
        n_red    = r_red;
        n_preset = r_preset;
        // counter chain first, then the presses in key order
        if (r_run) begin
            if (r_ms != MS_LAST) begin
                n_ms = r_ms + 1'b1;
            end else begin
                n_ms = '0;
                if (r_tenth != TENTH_LAST) begin
                    n_tenth = r_tenth + 1'b1;
                end else begin
                    n_tenth = '0;
                    if (r_second != SECOND_LAST) begin
                        n_second = r_second + 1'b1;
                    end else begin
                        n_second = '0;
                        n_minute = (r_minute >= MINUTE_LAST) ? 7'd0 : r_minute + 1'b1;
                    end
                end
            end
        end
        if (i_press[KEY_LEFT]) begin
            n_red = 1'b0;
        end
        if (i_press[KEY_RIGHT]) begin
            n_red = 1'b1;
        end
        if (i_press[KEY_UP]) begin
            n_ms     = '0;
            n_tenth  = '0;
            n_second = '0;
            n_minute = '0;
        end
        if (i_press[KEY_DOWN]) begin
            n_preset = next_preset(r_preset);
        end
        if (i_press[KEY_MID]) begin
            n_run = ~r_run;
        end

        o_result.minutes      = n_minute;
        o_result.seconds      = n_second;
        o_result.tenths       = n_tenth;
        o_result.running      = n_run;
        o_result.theme_red    = n_red;
        o_result.offset_index = n_preset;
        o_result.offset_x     = gap_x(n_preset);
        o_result.offset_y     = gap_y(n_preset);
        o_result.redraw_ui    = |(i_press & REDRAW_MASK);
        o_result.press_mask   = i_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms     <= '0;
            r_tenth  <= '0;
            r_second <= '0;
            r_minute <= '0;
            r_run    <= 1'b1;
            r_red    <= 1'b0;
            r_preset <= PRESET_RESET;
        end else if (i_step) begin
            r_ms     <= n_ms;
            r_tenth  <= n_tenth;
            r_second <= n_second;
            r_minute <= n_minute;
            r_run    <= n_run;
            r_red    <= n_red;
            r_preset <= n_preset;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/debounced_key_stopwatch_top.sv
// Debounced key stopwatch.
// Input channel: i_in_valid / o_in_stall carries one 1 ms tick with five raw
// active-low key levels. A transfer happens when i_in_valid is high and
// o_in_stall is low. Output channel: o_out_valid / i_out_stall carries one
// result per tick (time, run flag, theme, offset preset, presses).
// Configuration: i_cfg_valid / o_cfg_ready writes the debounce setting from
// i_cfg_data; o_cfg_ready is always high, write only while idle.
// Throughput: one tick per cycle while the receiver does not stall. The
// result is held in the output register from the cycle after its transfer.
// Five debounce lanes run in parallel on the keys of a tick, and the merge
// stage applies the presses to the counter chain in the same cycle.
// While the receiver stalls, the result holds and o_in_stall rises so no
// further tick is taken; a new tick is taken in the cycle the result leaves.
// Reset (i_rst_n low, synchronous) empties the output register, releases
// all keys, clears the time, sets running, white theme, preset one and a
// debounce setting of 40 ticks.
`default_nettype none
module debounced_key_stopwatch_top
    import dks_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_key_left,
    input  wire logic       i_key_right,
    input  wire logic       i_key_up,
    input  wire logic       i_key_down,
    input  wire logic       i_key_mid,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [6:0]      o_minutes,
    output logic [5:0]      o_seconds,
    output logic [3:0]      o_tenths,
    output logic            o_running,
    output logic            o_theme_red,
    output logic [1:0]      o_offset_index,
    output logic [5:0]      o_offset_x,
    output logic [6:0]      o_offset_y,
    output logic            o_redraw_ui,
    output logic [4:0]      o_press_mask,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0]          r_debounce;
    logic                r_out_valid;
    t_result             r_result;
    t_result             merge_result;
    logic                step;
    logic [NUM_KEYS-1:0] levels;
    logic [NUM_KEYS-1:0] press;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign step        = i_in_valid & ~o_in_stall;

    assign levels[KEY_LEFT]  = i_key_left;
    assign levels[KEY_RIGHT] = i_key_right;
    assign levels[KEY_UP]    = i_key_up;
    assign levels[KEY_DOWN]  = i_key_down;
    assign levels[KEY_MID]   = i_key_mid;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        dks_lane #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (step),
            .i_level    (levels[k]),
            .i_debounce (r_debounce),
            .o_press    (press[k])
        );
    end

    dks_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_press  (press),
        .o_result (merge_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= merge_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_minutes      = r_result.minutes;
    assign o_seconds      = r_result.seconds;
    assign o_tenths       = r_result.tenths;
    assign o_running      = r_result.running;
    assign o_theme_red    = r_result.theme_red;
    assign o_offset_index = r_result.offset_index;
    assign o_offset_x     = r_result.offset_x;
    assign o_offset_y     = r_result.offset_y;
    assign o_redraw_ui    = r_result.redraw_ui;
    assign o_press_mask   = r_result.press_mask;

endmodule
`default_nettype wire

>>> rtl/core/dks_checker.sv
`default_nettype none
module dks_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [6:0] o_minutes,
    input wire logic [5:0] o_seconds,
    input wire logic [3:0] o_tenths,
    input wire logic [1:0] o_offset_index,
    input wire logic [5:0] o_offset_x,
    input wire logic [6:0] o_offset_y
);

    // input side only held back by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // every input transfer yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("input transfer without result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_minutes) && $stable(o_seconds) && $stable(o_tenths)))
        else $error("stalled result changed");

    a_preset_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_offset_index != 2'd3 &&
            (o_offset_index != 2'd2 || (o_offset_y == 7'd80 && o_offset_x == 6'd0))))
        else $error("bad offset preset");

endmodule

bind debounced_key_stopwatch_top dks_checker u_dks_checker (.*);
`default_nettype wire
